@@ rtl/core/i2cm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned DATA_BITS  = 8;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned IN_TDATA_W = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CNT_W-1:0] BITS_LAST = CNT_W'(DATA_BITS);

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic                 send_start;
        logic                 send_stop;
        logic [DATA_BITS-1:0] tx_data;
        logic                 ack_after_read;
        logic                 sda_sample;
        logic                 scl_sample;
    } t_in_item;

    typedef struct packed {
        logic                 sda_drive_low;
        logic                 scl_drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] rx_data;
        logic                 nack;
        logic                 command_rejected;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/core/i2cm_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_in_stage
// Input register; refills in the same cycle the engine takes its request.
// ----------------------------------------------------------------------------
module i2cm_in_stage
    import i2cm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_ready,
    input  wire logic     i_take,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/i2cm_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Pin-step state machine and result register; one request per cycle while the result is taken.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_stretch_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_take,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    output t_result       o_result
);

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_RS_SDA_REL  = 5'd1,
        PH_RS_SCL_REL  = 5'd2,
        PH_ST_SDA_REL  = 5'd3,
        PH_ST_SDA_LOW  = 5'd4,
        PH_ST_SCL_LOW  = 5'd5,
        PH_BIT_SDA     = 5'd6,
        PH_BIT_SCL_REL = 5'd7,
        PH_BIT_SCL_LOW = 5'd8,
        PH_SP_SDA_LOW  = 5'd9,
        PH_SP_SCL_REL  = 5'd10,
        PH_SP_SDA_REL  = 5'd11
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic                 r_start_sent, n_start_sent;
    logic                 r_op_is_read, n_op_is_read;
    logic                 r_stop_pending, n_stop_pending;
    logic                 r_ack_pending, n_ack_pending;
    logic                 r_nack_flag, n_nack_flag;
    logic                 r_sda_low, n_sda_low;
    logic                 r_scl_low, n_scl_low;
    logic                 r_out_valid;
    t_result              r_result, n_result;

    logic is_cmd;
    logic held;
    logic done;
    logic rejected;
    logic reading;
    logic data_phase;

    assign o_take      = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign is_cmd = (i_item.command == CMD_WRITE) || (i_item.command == CMD_READ);
    assign held   = i_stretch_en && !i_item.scl_sample;

    always_comb begin
        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_shift        = r_shift;
        n_start_sent   = r_start_sent;
        n_op_is_read   = r_op_is_read;
        n_stop_pending = r_stop_pending;
        n_ack_pending  = r_ack_pending;
        n_nack_flag    = r_nack_flag;
        n_sda_low      = r_sda_low;
        n_scl_low      = r_scl_low;
        done           = 1'b0;
        rejected       = 1'b0;
        reading        = 1'b0;
        data_phase     = 1'b0;

        if (r_phase != PH_IDLE) begin
            rejected = is_cmd;
        end else if (is_cmd) begin
            n_op_is_read   = (i_item.command == CMD_READ);
            n_shift        = n_op_is_read ? '0 : i_item.tx_data;
            n_ack_pending  = n_op_is_read ? i_item.ack_after_read : 1'b0;
            n_stop_pending = i_item.send_stop;
            n_nack_flag    = 1'b0;
            n_bit_count    = '0;
            if (i_item.send_start) begin
                n_phase = r_start_sent ? PH_RS_SDA_REL : PH_ST_SDA_REL;
            end else begin
                n_phase = PH_BIT_SDA;
            end
        end

        data_phase = (n_bit_count < BITS_LAST);
        reading    = n_op_is_read ? data_phase : !data_phase;

        unique case (n_phase)
            PH_IDLE: begin
            end
            PH_RS_SDA_REL: begin
                n_sda_low = 1'b0;
                n_phase   = PH_RS_SCL_REL;
            end
            PH_RS_SCL_REL: begin
                n_scl_low = 1'b0;
                n_phase   = PH_ST_SDA_REL;
            end
            PH_ST_SDA_REL: begin
                if (!(n_start_sent && held)) begin
                    n_sda_low = 1'b0;
                    n_phase   = PH_ST_SDA_LOW;
                end
            end
            PH_ST_SDA_LOW: begin
                n_sda_low = 1'b1;
                n_phase   = PH_ST_SCL_LOW;
            end
            PH_ST_SCL_LOW: begin
                n_scl_low    = 1'b1;
                n_start_sent = 1'b1;
                n_phase      = PH_BIT_SDA;
            end
            PH_BIT_SDA: begin
                if (reading) begin
                    n_sda_low = 1'b0;
                end else if (data_phase) begin
                    n_sda_low = !n_shift[DATA_BITS-1];
                end else begin
                    n_sda_low = n_ack_pending;
                end
                n_phase = PH_BIT_SCL_REL;
            end
            PH_BIT_SCL_REL: begin
                n_scl_low = 1'b0;
                n_phase   = PH_BIT_SCL_LOW;
            end
            PH_BIT_SCL_LOW: begin
                if (!held) begin
                    if (data_phase) begin
                        n_shift = {n_shift[DATA_BITS-2:0],
                                   n_op_is_read & i_item.sda_sample};
                    end else if (!n_op_is_read) begin
                        n_nack_flag = i_item.sda_sample;
                    end
                    n_scl_low = 1'b1;
                    if (!data_phase) begin
                        n_bit_count = '0;
                        if (n_stop_pending) begin
                            n_phase = PH_SP_SDA_LOW;
                        end else begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end else begin
                        n_bit_count = n_bit_count + CNT_W'(1);
                        n_phase     = PH_BIT_SDA;
                    end
                end
            end
            PH_SP_SDA_LOW: begin
                n_sda_low = 1'b1;
                n_phase   = PH_SP_SCL_REL;
            end
            PH_SP_SCL_REL: begin
                n_scl_low = 1'b0;
                n_phase   = PH_SP_SDA_REL;
            end
            PH_SP_SDA_REL: begin
                if (!held) begin
                    n_sda_low    = 1'b0;
                    n_start_sent = 1'b0;
                    n_phase      = PH_IDLE;
                    done         = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_result.sda_drive_low    = n_sda_low;
        n_result.scl_drive_low    = n_scl_low;
        n_result.busy_res         = (n_phase != PH_IDLE);
        n_result.done_res         = done;
        n_result.rx_data          = (done && n_op_is_read) ? n_shift : '0;
        n_result.nack             = done && !n_op_is_read && n_nack_flag;
        n_result.command_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_count    <= '0;
            r_shift        <= '0;
            r_start_sent   <= 1'b0;
            r_op_is_read   <= 1'b0;
            r_stop_pending <= 1'b0;
            r_ack_pending  <= 1'b0;
            r_nack_flag    <= 1'b0;
            r_sda_low      <= 1'b0;
            r_scl_low      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_shift        <= n_shift;
                r_start_sent   <= n_start_sent;
                r_op_is_read   <= n_op_is_read;
                r_stop_pending <= n_stop_pending;
                r_ack_pending  <= n_ack_pending;
                r_nack_flag    <= n_nack_flag;
                r_sda_low      <= n_sda_low;
                r_scl_low      <= n_scl_low;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/i2c_master_byte_engine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Open-drain I2C master byte engine, one pin step per request.
// ----------------------------------------------------------------------------
// Each slave request is one tick: the current SDA/SCL samples plus an
// optional command (tuser: 0 tick, 1 byte write, 2 byte read). Each
// request returns exactly one result on the master side with the new pin
// drives, busy/done, received byte, nack and a rejected-command flag.
// Drive the open-drain pads from sda/scl_drive_low of each result.
// A request passes the input register, then the state machine and result
// register. Throughput: one request per cycle while the master side takes
// results; the state update of the pin sequencer settles combinationally,
// so requests stream back to back.
// A stalled master side holds the result register; the input register
// still takes one more request, then s_axis_tready drops until the
// result is taken.
// Reset (synchronous, active low) returns to idle with both lines
// released and clock stretching disabled. i_cfg_we/i_cfg_wdata set
// clock_stretch_enable; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [0] send_start, [1] send_stop, [9:2] tx_data, [10] ack_after_read,
    // [11] sda_sample, [12] scl_sample, [15:13] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  wire logic [CMD_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] sda_drive_low, [1] scl_drive_low, [2] busy_res, [3] done_res,
    // [11:4] rx_data, [12] nack, [13] command_rejected, [15:14] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic     r_stretch_en;
    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     take;
    t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stretch_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_stretch_en <= i_cfg_wdata;
        end
    end

    assign in_item.command        = s_axis_tuser;
    assign in_item.send_start     = s_axis_tdata[0];
    assign in_item.send_stop      = s_axis_tdata[1];
    assign in_item.tx_data        = s_axis_tdata[9:2];
    assign in_item.ack_after_read = s_axis_tdata[10];
    assign in_item.sda_sample     = s_axis_tdata[11];
    assign in_item.scl_sample     = s_axis_tdata[12];

    i2cm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (s_axis_tready),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    i2cm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stretch_en (r_stretch_en),
        .i_valid      (stage_valid),
        .i_item       (stage_item),
        .o_take       (take),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_result     (result)
    );

    assign m_axis_tdata = {2'b00,
                           result.command_rejected,
                           result.nack,
                           result.rx_data,
                           result.done_res,
                           result.busy_res,
                           result.scl_drive_low,
                           result.sda_drive_low};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done reported while still busy");

    a_rx_nack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[12] && (m_axis_tdata[11:4] != '0)))
        else $error("rx data and nack in the same result");

    a_done_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> (m_axis_tdata[1] || !m_axis_tdata[0]))
        else $error("done with SCL released and SDA held low");

    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> m_axis_tvalid)
        else $error("engine step produced no result");

endmodule
`default_nettype wire
